// ----- design/erm_pkg.sv -----
// Shared types, constants and the matrix entry table for the Euler rotation matrix block.
package erm_pkg;

  localparam int QF             = 30;
  localparam int SERIES_TERMS   = 10;
  localparam int STREAMS        = 6;
  localparam int ITEM_CYCLES    = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int TW             = 36;

  localparam logic signed [TW-1:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [TW-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [TW-1:0] TWO_PI_Q  = 36'sd6746518852;
  localparam logic [31:0]          Q_ONE     = 32'd1073741824;

  localparam logic [1:0] FUNC_XY  = 2'd0;
  localparam logic [1:0] FUNC_XYZ = 2'd1;
  localparam logic [1:0] FUNC_ZYX = 2'd2;

  // stream order in the cell chain matches the first six factor codes
  typedef enum logic [2:0] {
    FAC_SX, FAC_CX, FAC_SY, FAC_CY, FAC_SZ, FAC_CZ, FAC_ONE, FAC_ZERO
  } fac_t;

  // entry = +-((a*b)*c) +- (d*e), n1 and n2 negating their terms, each product rounded to Q30
  typedef struct packed {
    fac_t a;
    fac_t b;
    fac_t c;
    fac_t d;
    fac_t e;
    logic n1;
    logic n2;
  } ent_ops_t;

  typedef struct packed {
    logic              vld;
    logic              kind;   // 0 sine, 1 cosine
    logic              neg;
    logic [2:0]        idx;
    logic [1:0]        func;
    logic [31:0]       x2;
    logic [31:0]       term;
    logic signed [32:0] acc;
  } erm_tok_t;

  function automatic ent_ops_t mk(input fac_t a, input fac_t b, input fac_t c,
                                  input logic n1, input fac_t d, input fac_t e,
                                  input logic n2);
    ent_ops_t o;
    o.a  = a;
    o.b  = b;
    o.c  = c;
    o.n1 = n1;
    o.d  = d;
    o.e  = e;
    o.n2 = n2;
    return o;
  endfunction

  function automatic ent_ops_t ent_ops(input logic [1:0] func, input logic [3:0] k);
    ent_ops_t o;
    o = mk(FAC_ZERO, FAC_ZERO, FAC_ZERO, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
    if (k == 4'd15) begin
      o = mk(FAC_ONE, FAC_ONE, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
    end else begin
      case (func)
        FUNC_XY: begin
          case (k)
            4'd0:  o = mk(FAC_CY, FAC_ONE, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd2:  o = mk(FAC_SY, FAC_ONE, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd4:  o = mk(FAC_SX, FAC_SY, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd5:  o = mk(FAC_CX, FAC_ONE, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd6:  o = mk(FAC_SX, FAC_CY, FAC_ONE, 1'b1, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd8:  o = mk(FAC_CX, FAC_SY, FAC_ONE, 1'b1, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd9:  o = mk(FAC_SX, FAC_ONE, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd10: o = mk(FAC_CX, FAC_CY, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            default: ;
          endcase
        end
        FUNC_XYZ: begin
          case (k)
            4'd0:  o = mk(FAC_CY, FAC_CZ, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd1:  o = mk(FAC_CY, FAC_SZ, FAC_ONE, 1'b1, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd2:  o = mk(FAC_SY, FAC_ONE, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd4:  o = mk(FAC_CZ, FAC_SX, FAC_SY, 1'b0, FAC_CX, FAC_SZ, 1'b0);
            4'd5:  o = mk(FAC_SX, FAC_SY, FAC_SZ, 1'b1, FAC_CX, FAC_CZ, 1'b0);
            4'd6:  o = mk(FAC_CY, FAC_SX, FAC_ONE, 1'b1, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd8:  o = mk(FAC_CX, FAC_CZ, FAC_SY, 1'b1, FAC_SX, FAC_SZ, 1'b0);
            4'd9:  o = mk(FAC_CX, FAC_SY, FAC_SZ, 1'b0, FAC_CZ, FAC_SX, 1'b0);
            4'd10: o = mk(FAC_CX, FAC_CY, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            default: ;
          endcase
        end
        default: begin
          // zyx, also taken by the unused order code
          case (k)
            4'd0:  o = mk(FAC_CY, FAC_CZ, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd1:  o = mk(FAC_CZ, FAC_SX, FAC_SY, 1'b0, FAC_CX, FAC_SZ, 1'b1);
            4'd2:  o = mk(FAC_CX, FAC_CZ, FAC_SY, 1'b0, FAC_SX, FAC_SZ, 1'b0);
            4'd4:  o = mk(FAC_CY, FAC_SZ, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd5:  o = mk(FAC_SX, FAC_SY, FAC_SZ, 1'b0, FAC_CX, FAC_CZ, 1'b0);
            4'd6:  o = mk(FAC_CX, FAC_SY, FAC_SZ, 1'b0, FAC_CZ, FAC_SX, 1'b1);
            4'd8:  o = mk(FAC_SY, FAC_ONE, FAC_ONE, 1'b1, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd9:  o = mk(FAC_CY, FAC_SX, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            4'd10: o = mk(FAC_CX, FAC_CY, FAC_ONE, 1'b0, FAC_ZERO, FAC_ZERO, 1'b0);
            default: ;
          endcase
        end
      endcase
    end
    return o;
  endfunction

endpackage

// ----- design/euler_rotation_matrix.sv -----
// Euler-angle 4x4 rotation matrix generator: top level.
// A command (start while busy is low) carries the order code and three angles in Q4
// radians; the block answers with the sixteen matrix entries in row-major order, one per
// cycle on consecutive cycles, each marked by out_valid, entry 15 also by
// out_last_element. The results cannot be held off. Busy goes high after each transfer
// and stays high until a down-counter loaded with ITEM_CYCLES - 1 runs out, so commands
// are taken no faster than the entry stream is sent. Between the transfer and the first
// entry lie four angle feed stages, a chain of ten series cells of four stages each, the
// collection of the six sine/cosine streams and five product, rounding and output stages
// in the entry datapath. No reset sweep.
module euler_rotation_matrix
  import erm_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_func,
  input  logic signed [ANGLE_BITS-1:0] in_angle_x,
  input  logic signed [ANGLE_BITS-1:0] in_angle_y,
  input  logic signed [ANGLE_BITS-1:0] in_angle_z,
  output logic                         out_valid,
  output logic [3:0]                   out_element_index,
  output logic signed [VALUE_BITS-1:0] out_element_value,
  output logic                         out_last_element
);

  logic [3:0] busy_cnt_r;
  logic       accept;
  erm_tok_t   chain [SERIES_TERMS + 1];

  assign busy   = (busy_cnt_r != 4'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= '0;
    end else if (accept) begin
      busy_cnt_r <= 4'(ITEM_CYCLES - 1);
    end else if (busy) begin
      busy_cnt_r <= busy_cnt_r - 4'd1;
    end
  end

  erm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .func    (in_func),
    .angle_x (in_angle_x),
    .angle_y (in_angle_y),
    .angle_z (in_angle_z),
    .tok     (chain[0])
  );

  for (genvar g = 1; g <= SERIES_TERMS; g++) begin : g_cell
    erm_cell #(.K(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g-1]),
      .tok_o (chain[g])
    );
  end

  erm_mat #(.VALUE_BITS(VALUE_BITS)) u_mat (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok               (chain[SERIES_TERMS]),
    .out_valid         (out_valid),
    .out_element_index (out_element_index),
    .out_element_value (out_element_value),
    .out_last_element  (out_last_element)
  );

`ifndef SYNTH
  localparam logic signed [VALUE_BITS-1:0] VONE = VALUE_BITS'(64'd1 << (VALUE_BITS - 2));

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after a transfer");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_element) |=>
      (out_valid && out_element_index == $past(out_element_index) + 4'd1))
    else $error("entry stream broken");

  a_index_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_element_index != 4'd0) |-> $past(out_valid))
    else $error("entry stream started mid-matrix");

  a_value_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_element_value <= VONE && out_element_value >= -VONE))
    else $error("entry outside plus or minus one");
`endif

endmodule

// ----- design/erm_front.sv -----
// Angle feed: issues six sine/cosine streams per item, reduces and folds each angle.
module erm_front
  import erm_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [1:0]                   func,
  input  logic signed [ANGLE_BITS-1:0] angle_x,
  input  logic signed [ANGLE_BITS-1:0] angle_y,
  input  logic signed [ANGLE_BITS-1:0] angle_z,
  output erm_tok_t                     tok
);

  localparam int SH = 34 - ANGLE_BITS;

  logic signed [ANGLE_BITS-1:0] ang_x_r, ang_y_r, ang_z_r;
  logic [1:0]                   func_r;
  logic                         feed_act_r;
  logic [2:0]                   feed_cnt_r;

  logic                 f1_vld_r, f2_vld_r, f3_vld_r, f4_vld_r;
  logic [2:0]           f1_idx_r, f2_idx_r, f3_idx_r, f4_idx_r;
  logic [1:0]           f1_func_r, f2_func_r, f3_func_r, f4_func_r;
  logic signed [TW-1:0] f1_t_r, f1_t_nxt;
  logic [34:0]          f2_mag_r;
  logic                 f2_sneg_r, f3_sneg_r, f4_sneg_r;
  logic                 f3_cneg_r, f4_cneg_r;
  logic [30:0]          f3_m_r, f4_m_r;
  logic [61:0]          f4_mm_r;

  logic signed [ANGLE_BITS-1:0] a_sel;
  logic signed [TW-1:0]         t_full;
  logic [62:0]                  x2_sum;

  always_ff @(posedge clk) begin
    if (load) begin
      ang_x_r <= angle_x;
      ang_y_r <= angle_y;
      ang_z_r <= angle_z;
      func_r  <= func;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_act_r <= 1'b0;
      feed_cnt_r <= '0;
    end else if (load) begin
      feed_act_r <= 1'b1;
      feed_cnt_r <= '0;
    end else if (feed_act_r) begin
      if (feed_cnt_r == 3'(STREAMS - 1)) begin
        feed_act_r <= 1'b0;
      end else begin
        feed_cnt_r <= feed_cnt_r + 3'd1;
      end
    end
  end

  always_comb begin
    case (feed_cnt_r[2:1])
      2'd0:    a_sel = ang_x_r;
      2'd1:    a_sel = ang_y_r;
      default: a_sel = ang_z_r;
    endcase
    t_full = TW'(a_sel) <<< SH;
    // one wrap is enough for a Q4 angle
    if (t_full > PI_Q) begin
      f1_t_nxt = t_full - TWO_PI_Q;
    end else if (t_full < -PI_Q) begin
      f1_t_nxt = t_full + TWO_PI_Q;
    end else begin
      f1_t_nxt = t_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= feed_act_r;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_idx_r  <= feed_cnt_r;
    f1_func_r <= func_r;
    f1_t_r    <= f1_t_nxt;

    f2_idx_r  <= f1_idx_r;
    f2_func_r <= f1_func_r;
    f2_sneg_r <= f1_t_r[TW-1];
    f2_mag_r  <= 35'(f1_t_r[TW-1] ? -f1_t_r : f1_t_r);

    f3_idx_r  <= f2_idx_r;
    f3_func_r <= f2_func_r;
    f3_sneg_r <= f2_sneg_r;
    // fold into the first quadrant, cosine flips sign
    if (f2_mag_r > 35'(HALF_PI_Q)) begin
      f3_m_r    <= 31'(35'(PI_Q) - f2_mag_r);
      f3_cneg_r <= 1'b1;
    end else begin
      f3_m_r    <= 31'(f2_mag_r);
      f3_cneg_r <= 1'b0;
    end

    f4_idx_r  <= f3_idx_r;
    f4_func_r <= f3_func_r;
    f4_sneg_r <= f3_sneg_r;
    f4_cneg_r <= f3_cneg_r;
    f4_m_r    <= f3_m_r;
    f4_mm_r   <= 62'(f3_m_r) * 62'(f3_m_r);
  end

  always_comb begin
    x2_sum    = 63'(f4_mm_r) + (63'd1 << (QF - 1));
    tok.vld   = f4_vld_r;
    tok.kind  = f4_idx_r[0];
    tok.neg   = f4_idx_r[0] ? f4_cneg_r : f4_sneg_r;
    tok.idx   = f4_idx_r;
    tok.func  = f4_func_r;
    tok.x2    = x2_sum[61:30];
    tok.term  = f4_idx_r[0] ? Q_ONE : {1'b0, f4_m_r};
    tok.acc   = f4_idx_r[0] ? $signed({1'b0, Q_ONE}) : $signed({2'b00, f4_m_r});
  end

endmodule

// ----- design/erm_cell.sv -----
// One series cell: next Taylor term of a sine or cosine stream and accumulate it.
module erm_cell
  import erm_pkg::*;
#(
  parameter int K = 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  erm_tok_t tok_i,
  output erm_tok_t tok_o
);

  localparam int unsigned DS = (2 * K) * (2 * K + 1);
  localparam int unsigned DC = (2 * K - 1) * (2 * K);
  localparam logic [31:0] RS = 32'((64'd1 << 32) / DS);
  localparam logic [31:0] RC = 32'((64'd1 << 32) / DC);
  localparam logic [8:0]  DS9 = 9'(DS);
  localparam logic [8:0]  DC9 = 9'(DC);

  erm_tok_t    s1_tok_r, s2_tok_r, s3_tok_r, s4_tok_r;
  logic [63:0] s1_p_r;
  logic [31:0] s2_q_r, s3_q_r;
  logic [63:0] s2_p_r;
  logic [31:0] s3_est_r;
  logic [40:0] s3_ed_r;

  logic [31:0] q_nxt;
  logic [41:0] rem;
  logic [31:0] tnew;
  logic [8:0]  d_s3;
  erm_tok_t    s4_nxt;

  assign q_nxt = s1_p_r[61:30];
  assign d_s3  = s3_tok_r.kind ? DC9 : DS9;

  always_comb begin
    rem    = {10'd0, s3_q_r} - 42'(s3_ed_r);
    // reciprocal estimate is at most one short
    tnew   = s3_est_r + ((rem >= 42'(d_s3)) ? 32'd1 : 32'd0);
    s4_nxt = s3_tok_r;
    s4_nxt.term = tnew;
    if (K % 2 == 1) begin
      s4_nxt.acc = s3_tok_r.acc - $signed({1'b0, tnew});
    end else begin
      s4_nxt.acc = s3_tok_r.acc + $signed({1'b0, tnew});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r <= '0;
      s2_tok_r <= '0;
      s3_tok_r <= '0;
      s4_tok_r <= '0;
    end else begin
      s1_tok_r <= tok_i;
      s2_tok_r <= s1_tok_r;
      s3_tok_r <= s2_tok_r;
      s4_tok_r <= s4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_p_r   <= 64'(tok_i.term) * 64'(tok_i.x2);
    s2_q_r   <= q_nxt;
    s2_p_r   <= 64'(q_nxt) * 64'(s1_tok_r.kind ? RC : RS);
    s3_q_r   <= s2_q_r;
    s3_est_r <= s2_p_r[63:32];
    s3_ed_r  <= 41'(s2_p_r[63:32]) * 41'(s2_tok_r.kind ? DC9 : DS9);
  end

  assign tok_o = s4_tok_r;

endmodule

// ----- design/erm_mat.sv -----
// Matrix emitter: collects the six sines and cosines and streams the sixteen entries.
module erm_mat
  import erm_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  erm_tok_t                     tok,
  output logic                         out_valid,
  output logic [3:0]                   out_element_index,
  output logic signed [VALUE_BITS-1:0] out_element_value,
  output logic                         out_last_element
);

  localparam int SH = 32 - VALUE_BITS;
  localparam int VF = VALUE_BITS - 2;
  localparam logic signed [TW-1:0] RND_V = TW'((64'd1 << SH) >> 1);
  localparam logic signed [TW-1:0] ONE_V = TW'(64'd1 << VF);
  localparam logic signed [32:0]   F_ONE = 33'sd1073741824;

  logic signed [32:0] col_r [STREAMS];
  logic signed [32:0] hsx_r, hcx_r, hsy_r, hcy_r, hsz_r, hcz_r;
  logic [1:0]         hfunc_r;
  logic               act_r;
  logic [3:0]         cnt_r;

  logic               e1_vld_r, e2_vld_r, e3_vld_r, e4_vld_r;
  logic [3:0]         e1_k_r, e2_k_r, e3_k_r, e4_k_r;
  logic               e1_n1_r, e2_n1_r, e3_n1_r;
  logic               e1_n2_r, e2_n2_r, e3_n2_r;
  logic signed [65:0] e1_pab_r, e1_pde_r;
  logic signed [32:0] e1_fc_r, e2_fc_r;
  logic signed [32:0] e2_qab_r, e2_qde_r, e3_qde_r;
  logic signed [65:0] e3_p3_r;
  logic signed [34:0] e4_sum_r;

  logic               vld_r;
  logic [3:0]         idx_r;
  logic signed [VALUE_BITS-1:0] val_r;
  logic               last_r;

  logic signed [32:0] tv;
  logic               arrive;
  ent_ops_t           ops;
  logic signed [32:0] r3;
  logic signed [TW-1:0] vw, vr, vc;

  function automatic logic signed [32:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] s;
    // half away from zero in one add
    s = p + (p[65] ? 66'sd536870911 : 66'sd536870912);
    return 33'(s >>> QF);
  endfunction

  function automatic logic signed [32:0] fval(input fac_t f);
    case (f)
      FAC_SX:  return hsx_r;
      FAC_CX:  return hcx_r;
      FAC_SY:  return hsy_r;
      FAC_CY:  return hcy_r;
      FAC_SZ:  return hsz_r;
      FAC_CZ:  return hcz_r;
      FAC_ONE: return F_ONE;
      default: return '0;
    endcase
  endfunction

  assign tv     = tok.neg ? -tok.acc : tok.acc;
  assign arrive = tok.vld && (tok.idx == 3'(STREAMS - 1));
  assign ops    = ent_ops(hfunc_r, cnt_r);

  always_ff @(posedge clk) begin
    if (tok.vld) begin
      col_r[tok.idx] <= tv;
    end
    if (arrive) begin
      hsx_r   <= col_r[0];
      hcx_r   <= col_r[1];
      hsy_r   <= col_r[2];
      hcy_r   <= col_r[3];
      hsz_r   <= col_r[4];
      hcz_r   <= tv;
      hfunc_r <= tok.func;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (arrive) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      if (cnt_r == 4'(ITEM_CYCLES - 1)) begin
        act_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
      e4_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      e1_vld_r <= act_r;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
      e4_vld_r <= e3_vld_r;
      vld_r    <= e4_vld_r;
    end
  end

  always_comb begin
    r3 = rnd30(e3_p3_r);
    vw = TW'(e4_sum_r);
    if (SH > 0) begin
      vr = (vw + (vw[TW-1] ? RND_V - TW'(1) : RND_V)) >>> SH;
    end else begin
      vr = vw;
    end
    if (vr > ONE_V) begin
      vc = ONE_V;
    end else if (vr < -ONE_V) begin
      vc = -ONE_V;
    end else begin
      vc = vr;
    end
  end

  always_ff @(posedge clk) begin
    e1_k_r   <= cnt_r;
    e1_n1_r  <= ops.n1;
    e1_n2_r  <= ops.n2;
    e1_pab_r <= 66'(fval(ops.a)) * 66'(fval(ops.b));
    e1_pde_r <= 66'(fval(ops.d)) * 66'(fval(ops.e));
    e1_fc_r  <= fval(ops.c);

    e2_k_r   <= e1_k_r;
    e2_n1_r  <= e1_n1_r;
    e2_n2_r  <= e1_n2_r;
    e2_fc_r  <= e1_fc_r;
    e2_qab_r <= rnd30(e1_pab_r);
    e2_qde_r <= rnd30(e1_pde_r);

    e3_k_r   <= e2_k_r;
    e3_n1_r  <= e2_n1_r;
    e3_n2_r  <= e2_n2_r;
    e3_qde_r <= e2_qde_r;
    e3_p3_r  <= 66'(e2_qab_r) * 66'(e2_fc_r);

    e4_k_r   <= e3_k_r;
    e4_sum_r <= (e3_n1_r ? -35'(r3) : 35'(r3)) + (e3_n2_r ? -35'(e3_qde_r) : 35'(e3_qde_r));

    idx_r    <= e4_k_r;
    last_r   <= (e4_k_r == 4'(ITEM_CYCLES - 1));
    val_r    <= VALUE_BITS'(vc);
  end

  assign out_valid         = vld_r;
  assign out_element_index = idx_r;
  assign out_element_value = val_r;
  assign out_last_element  = vld_r && last_r;

endmodule

// ----- tb/euler_rotation_matrix_tb.sv -----
// Testbench for the Euler rotation matrix generator: directed and random commands checked per entry.
module euler_rotation_matrix_tb;
  import erm_pkg::*;

  localparam int AB = 16;
  localparam int VB = 16;
  localparam int AFRAC = AB - 4;
  localparam int VFRAC = VB - 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [3:0]           index;
    logic signed [VB-1:0] value;
    logic                 last;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = FUNC_XY;
  logic signed [AB-1:0] in_angle_x = '0;
  logic signed [AB-1:0] in_angle_y = '0;
  logic signed [AB-1:0] in_angle_z = '0;
  logic out_valid;
  logic [3:0] out_element_index;
  logic signed [VB-1:0] out_element_value;
  logic out_last_element;

  entry_t expected_entries[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;

  euler_rotation_matrix #(.ANGLE_BITS(AB), .VALUE_BITS(VB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_angle_x(in_angle_x), .in_angle_y(in_angle_y),
    .in_angle_z(in_angle_z), .out_valid(out_valid),
    .out_element_index(out_element_index), .out_element_value(out_element_value),
    .out_last_element(out_last_element)
  );

  always #5 clk = ~clk;

  function automatic longint round_mul(input longint a, input longint b);
    longint p;
    longint r;
    p = a * b;
    r = ((p < 0 ? -p : p) + (64'sd1 <<< (QF - 1))) >>> QF;
    return (p < 0) ? -r : r;
  endfunction

  task automatic sine_cosine(input logic signed [AB-1:0] ang, output longint s,
                             output longint c);
    longint t;
    longint m;
    longint x2;
    longint term;
    longint sacc;
    longint cacc;
    bit sneg;
    bit cneg;
    t = longint'(ang) * (64'sd1 <<< (QF - AFRAC));
    cneg = 1'b0;
    while (t > longint'(PI_Q)) t -= longint'(TWO_PI_Q);
    while (t < -longint'(PI_Q)) t += longint'(TWO_PI_Q);
    sneg = t < 0;
    m = sneg ? -t : t;
    if (m > longint'(HALF_PI_Q)) begin
      m = longint'(PI_Q) - m;
      cneg = 1'b1;
    end
    x2 = (m * m + (64'sd1 <<< (QF - 1))) >>> QF;
    term = m;
    sacc = m;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * x2) >>> QF) / ((2 * k) * (2 * k + 1));
      sacc += (k & 1) ? -term : term;
    end
    term = 64'sd1 <<< QF;
    cacc = term;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * x2) >>> QF) / ((2 * k - 1) * (2 * k));
      cacc += (k & 1) ? -term : term;
    end
    s = sneg ? -sacc : sacc;
    c = cneg ? -cacc : cacc;
  endtask

  function automatic logic signed [VB-1:0] to_entry(input longint v);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (64'sd1 <<< (QF - VFRAC - 1))) >>> (QF - VFRAC);
    if (mag > (64'sd1 <<< VFRAC)) mag = 64'sd1 <<< VFRAC;
    return VB'(v < 0 ? -mag : mag);
  endfunction

  task automatic predict_matrix(input logic [1:0] func, input logic signed [AB-1:0] ax,
                                input logic signed [AB-1:0] ay,
                                input logic signed [AB-1:0] az);
    longint m[16];
    longint sx, cx, sy, cy, sz, cz;
    entry_t e;
    sine_cosine(ax, sx, cx);
    sine_cosine(ay, sy, cy);
    sine_cosine(az, sz, cz);
    foreach (m[k]) m[k] = 0;
    m[15] = 64'sd1 <<< QF;
    if (func == FUNC_XY) begin
      m[0] = cy;
      m[2] = sy;
      m[4] = round_mul(sx, sy);
      m[5] = cx;
      m[6] = -round_mul(sx, cy);
      m[8] = -round_mul(cx, sy);
      m[9] = sx;
      m[10] = round_mul(cx, cy);
    end else if (func == FUNC_XYZ) begin
      m[0] = round_mul(cy, cz);
      m[1] = -round_mul(cy, sz);
      m[2] = sy;
      m[4] = round_mul(round_mul(cz, sx), sy) + round_mul(cx, sz);
      m[5] = round_mul(cx, cz) - round_mul(round_mul(sx, sy), sz);
      m[6] = -round_mul(cy, sx);
      m[8] = -round_mul(round_mul(cx, cz), sy) + round_mul(sx, sz);
      m[9] = round_mul(cz, sx) + round_mul(round_mul(cx, sy), sz);
      m[10] = round_mul(cx, cy);
    end else begin
      // zyx, also taken by the unused order code
      m[0] = round_mul(cy, cz);
      m[1] = round_mul(round_mul(cz, sx), sy) - round_mul(cx, sz);
      m[2] = round_mul(round_mul(cx, cz), sy) + round_mul(sx, sz);
      m[4] = round_mul(cy, sz);
      m[5] = round_mul(cx, cz) + round_mul(round_mul(sx, sy), sz);
      m[6] = -round_mul(cz, sx) + round_mul(round_mul(cx, sy), sz);
      m[8] = -sy;
      m[9] = round_mul(cy, sx);
      m[10] = round_mul(cx, cy);
    end
    for (int k = 0; k < 16; k++) begin
      e.index = 4'(k);
      e.value = to_entry(m[k]);
      e.last = (k == 15);
      expected_entries.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Present one command, hold it until the transfer, then predict its entries.
  // Start stays high after the transfer; a gap before the next command or the caller drops it.
  task automatic send_command(input logic [1:0] func, input logic signed [AB-1:0] ax,
                              input logic signed [AB-1:0] ay,
                              input logic signed [AB-1:0] az);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    do @(posedge clk); while (busy);
    predict_matrix(func, ax, ay, az);
  endtask

  always @(posedge clk) begin
    entry_t e;
    if (rst_n && out_valid) begin
      if (expected_entries.size() == 0) begin
        report_mismatch("unexpected entry index", out_element_index, -1);
      end else begin
        e = expected_entries.pop_front();
        if (out_element_index !== e.index)
          report_mismatch("element_index", out_element_index, e.index);
        if (out_element_value !== e.value)
          report_mismatch("element_value", out_element_value, e.value);
        if (out_last_element !== e.last)
          report_mismatch("last_element", out_last_element, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("euler_rotation_matrix_tb failed");
      $finish;
    end
  end

  task automatic test_orders_and_extremes();
    logic signed [AB-1:0] ext[5] = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd6434, -16'sd6434};
    for (int f = 0; f < 4; f++) begin
      send_command(2'(f), 16'sd2145, -16'sd3000, 16'sd1000);
      send_command(2'(f), 16'sd0, 16'sd0, 16'sd0);
    end
    foreach (ext[i]) send_command(FUNC_ZYX, ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5]);
    // near pi/2 and pi, to hit the fold and exact one
    send_command(FUNC_XYZ, 16'sd6434, 16'sd12868, -16'sd12868);
    send_command(FUNC_XY, 16'sh7fff, -16'sh8000, 16'sh7fff);
    send_command(2'd3, -16'sh8000, 16'sh7fff, -16'sd1);
    send_command(FUNC_XYZ, 16'sd25736, -16'sd25736, 16'sd1);
  endtask

  task automatic test_random(input int count);
    logic signed [AB-1:0] a[3];
    for (int n = 0; n < count; n++) begin
      foreach (a[i]) begin
        if ($urandom_range(3) == 0) a[i] = AB'($urandom_range(25736) - 12868);
        else a[i] = AB'($urandom);
      end
      send_command(2'($urandom_range(3)), a[0], a[1], a[2]);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 28;
    test_orders_and_extremes();
    test_random(30);
    send_gap_pct = 61;
    test_random(30);
    send_gap_pct = 0;
    test_random(30);
    start <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("euler_rotation_matrix_tb passed");
    end else begin
      $display("euler_rotation_matrix_tb failed");
    end
    $finish;
  end

endmodule
